@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh - shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a rising clk edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/phbc_pkg.sv @@
// ----------------------------------------------------------------------------
// phbc_pkg - shared types and constants for the polynomial hash bucket block
// Register indexes, reset values, divider step counts, control structs.
// ----------------------------------------------------------------------------
package phbc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [1:0] REG_MODULUS    = 2'd1;
  localparam logic [1:0] REG_TABLE_SIZE = 2'd2;

  // Register reset values
  localparam logic [31:0] MULTIPLIER_RST = 32'd31;
  localparam logic [31:0] MODULUS_RST    = 32'd65521;
  localparam logic [5:0]  TABLE_SIZE_RST = 6'd18;

  // Collision counter saturation
  localparam logic [9:0] COUNT_MAX = 10'd1023;

  // Divider: two quotient bits per step
  localparam int          CNT_W       = 6;
  localparam logic [5:0]  STEPS_MAIN  = 6'd32;  // 64-bit dividend
  localparam logic [5:0]  STEPS_BKT   = 6'd16;  // 32-bit dividend

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch input item
    logic mul;       // product = running hash * multiplier
    logic div_load;  // start hash reduction by modulus
    logic commit;    // store reduced hash as running hash
    logic bkt_load;  // latch key hash, start reduction by table size
    logic emit;      // write result, update occupancy and count
  } phbc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_busy;  // divider still iterating
    logic last_key;  // latched item closes a key
    logic out_busy;  // output register full and not taken
  } phbc_sts_t;

endpackage

@@ rtl/poly_hash_bucket_collision.sv @@
// ----------------------------------------------------------------------------
// poly_hash_bucket_collision - rolling polynomial hash with bucket collisions
//
//   channel | direction | handshake         | payload
//   s       | in        | s_tvalid/s_tready | key byte, last of key, last of set
//   m       | out       | m_tvalid/m_tready | hash, bucket, collided, total, done
//   cfg     | in        | cfg_we            | multiplier, modulus, table size
//
// A byte that does not close a key goes, from acceptance to the next acceptance, through
// a multiply state, a divider load, the radix-4 steps of the shared divider reducing
// the 64-bit sum by the modulus, and a commit as the divider finishes, then back to ready.
// A closing byte instead starts the bucket reduction by the table size, waits for it
// to finish, then emits the result.
// Reset (rst, synchronous) clears the occupancy bits and count at once.
// A stalled output holds its item; the next item is still taken and worked on,
// and waits only at emit while the output register is full.
// ----------------------------------------------------------------------------
module poly_hash_bucket_collision import phbc_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // key byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] key_char
  input  logic        s_tlast,   // last_of_key
  input  logic        s_tuser,   // last_of_set
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] key_hash, [36:32] bucket,
                                 // [37] collided, [47:38] collision_total
  output logic        m_tlast    // set_done
);

  phbc_cmd_t   cmd;
  phbc_sts_t   sts;
  logic [31:0] key_hash;
  logic [4:0]  bucket;
  logic        collided;
  logic [9:0]  collision_total;

  phbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  phbc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .key_char        (s_tdata),
    .last_of_key     (s_tlast),
    .last_of_set     (s_tuser),
    .key_hash        (key_hash),
    .bucket          (bucket),
    .collided        (collided),
    .collision_total (collision_total),
    .set_done        (m_tlast),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .cmd             (cmd),
    .sts             (sts)
  );

  assign m_tdata = {collision_total, collided, bucket, key_hash};

endmodule

@@ rtl/phbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// phbc_ctrl - sequencing state machine
// Multiply, modulus reduction, then commit or bucket reduction and emit.
// ----------------------------------------------------------------------------
module phbc_ctrl import phbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  phbc_sts_t  sts,
  output phbc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_BKT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          if (sts.last_key) begin
            cmd.bkt_load = 1'b1;
            state_next   = S_BKT;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_BKT: begin
        if (!sts.div_busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // wait for a free output register
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/phbc_dp.sv @@
// ----------------------------------------------------------------------------
// phbc_dp - hash datapath
// Config registers, multiplier, shared radix-4 divider, occupancy bits,
// collision counter and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module phbc_dp import phbc_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // input item
  input  logic [7:0]  key_char,
  input  logic        last_of_key,
  input  logic        last_of_set,
  // result item
  output logic [31:0] key_hash,
  output logic [4:0]  bucket,
  output logic        collided,
  output logic [9:0]  collision_total,
  output logic        set_done,
  output logic        out_valid,
  input  logic        out_ready,
  // control
  input  phbc_cmd_t   cmd,
  output phbc_sts_t   sts
);

  // table_size is 6 bits, so no more than 63 buckets are ever addressed
  localparam int OCC_N = (TABLE_DEPTH < 63) ? TABLE_DEPTH : 63;
  localparam int OCC_W = (OCC_N > 1) ? $clog2(OCC_N) : 1;
  localparam logic [5:0] OCC_MAX = 6'(OCC_N);

  logic [31:0] multiplier;
  logic [31:0] modulus;
  logic [5:0]  table_size;

  logic [7:0]  byte_q;
  logic        last_key_q;
  logic        last_set_q;
  logic [31:0] running_hash;
  logic [63:0] prod;
  logic [31:0] hash_lo;
  logic [31:0] key_hash_q;

  logic [63:0] div_n;
  logic [31:0] div_d;
  logic [31:0] rem;
  logic [CNT_W-1:0] cnt;

  logic [OCC_N-1:0] occ;
  logic [9:0]       coll_cnt;

  logic [63:0] sum;
  logic [32:0] r1_sh;
  logic [31:0] r1;
  logic [32:0] r2_sh;
  logic [31:0] r2;
  logic [31:0] hash_w;
  logic [5:0]  eff_size;
  logic [OCC_W-1:0] occ_idx;
  logic        hit;
  logic [9:0]  coll_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULTIPLIER_RST;
      modulus    <= MODULUS_RST;
      table_size <= TABLE_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MULTIPLIER: multiplier <= cfg_wdata;
        REG_MODULUS:    modulus    <= cfg_wdata;
        REG_TABLE_SIZE: table_size <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // bucket count in use: zero means one, capped at the table depth
  always_comb begin
    if (table_size == 6'd0) begin
      eff_size = 6'd1;
    end else if (table_size > OCC_MAX) begin
      eff_size = OCC_MAX;
    end else begin
      eff_size = table_size;
    end
  end

  assign sum = prod + {56'd0, byte_q};

  // modulus zero keeps the low 32 bits of the sum
  assign hash_w = (modulus == 32'd0) ? hash_lo : rem;

  // two restoring division steps
  always_comb begin
    r1_sh = {rem, div_n[63]};
    r1    = (r1_sh >= {1'b0, div_d}) ? 32'(r1_sh - {1'b0, div_d}) : r1_sh[31:0];
    r2_sh = {r1, div_n[62]};
    r2    = (r2_sh >= {1'b0, div_d}) ? 32'(r2_sh - {1'b0, div_d}) : r2_sh[31:0];
  end

  // item capture, multiply, divider
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_q     <= key_char;
      last_key_q <= last_of_key;
      last_set_q <= last_of_set;
    end
    if (cmd.mul) begin
      prod <= running_hash * multiplier;
    end
    if (cmd.div_load) begin
      div_n   <= sum;
      hash_lo <= sum[31:0];
      div_d   <= modulus;
      rem     <= '0;
    end else if (cmd.bkt_load) begin
      div_n   <= {hash_w, 32'd0};
      div_d   <= {26'd0, eff_size};
      rem     <= '0;
    end else if (cnt != '0) begin
      div_n   <= {div_n[61:0], 2'b00};
      rem     <= r2;
    end
  end

  // divider step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_load) begin
      cnt <= STEPS_MAIN;
    end else if (cmd.bkt_load) begin
      cnt <= STEPS_BKT;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // bucket lookup and saturating count
  assign occ_idx   = rem[OCC_W-1:0];
  assign hit       = occ[occ_idx];
  assign coll_next = (hit && coll_cnt < COUNT_MAX) ? coll_cnt + 10'd1 : coll_cnt;

  // running hash, occupancy, collision count
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      occ          <= '0;
      coll_cnt     <= '0;
    end else begin
      if (cmd.commit) begin
        running_hash <= hash_w;
      end
      if (cmd.emit) begin
        running_hash <= '0;
        if (last_set_q) begin
          occ      <= '0;
          coll_cnt <= '0;
        end else begin
          occ[occ_idx] <= 1'b1;
          coll_cnt     <= coll_next;
        end
      end
    end
  end

  // key hash holds across the bucket reduction, output register loads at emit
  always_ff @(posedge clk) begin
    if (cmd.bkt_load) begin
      key_hash_q <= hash_w;
    end
    if (cmd.emit) begin
      key_hash        <= key_hash_q;
      bucket          <= rem[4:0];
      collided        <= hit;
      collision_total <= coll_next;
      set_done        <= last_set_q;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.div_busy = (cnt != '0);
  assign sts.last_key = last_key_q;
  assign sts.out_busy = out_valid && !out_ready;

  `ASSERT_NEVER(a_load_while_busy, (cmd.div_load || cmd.bkt_load) && (cnt != '0), "divider restarted mid-run")
  `ASSERT_NEVER(a_emit_over_held, cmd.emit && out_valid && !out_ready, "result overwrote a held item")
  `ASSERT_CLK(a_set_clear, (cmd.emit && last_set_q) |=> (coll_cnt == '0 && occ == '0), "set not cleared")

endmodule

@@ tb/sv/poly_hash_bucket_collision_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_hash_bucket_collision_tb - self-checking bench for the hash bucket block
// Streams key bytes under several register settings, predicts every result
// (hash, bucket, collision flag, saturating count, set end) and compares.
// ----------------------------------------------------------------------------
module poly_hash_bucket_collision_tb;
  import phbc_pkg::*;

  localparam int          TABLE_DEPTH = 32;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;   // index with no register behind it
  localparam int          SETTLE      = 100;    // cycles for a byte still in flight
  localparam int          HOLD_CYCLES = 700;    // long receiver hold-off
  localparam int          STALL_LIMIT = 5000;   // cycles with no item moved
  localparam int          SAT_KEYS    = 1030;   // enough hits to pin the counter

  // one predicted result item
  typedef struct packed {
    logic [31:0] key_hash;
    logic [4:0]  bucket;
    logic        collided;
    logic [9:0]  total;
    logic        set_done;
  } bucket_result_t;

  // Keeps a private copy of registers and block state, queues predictions
  class hash_scoreboard;
    logic [31:0]            mult;
    logic [31:0]            modv;
    logic [5:0]             tsize;
    logic [31:0]            run_hash;
    logic [TABLE_DEPTH-1:0] occupied;
    logic [9:0]             hits;
    bucket_result_t         pending_q[$];
    int                     mismatches;
    int                     checked;
    int                     sets_closed;
    int                     peak_total;

    function new();
      mult        = MULTIPLIER_RST;
      modv        = MODULUS_RST;
      tsize       = TABLE_SIZE_RST;
      run_hash    = '0;
      occupied    = '0;
      hits        = '0;
      mismatches  = 0;
      checked     = 0;
      sets_closed = 0;
      peak_total  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MULTIPLIER: mult  = val;
        REG_MODULUS:    modv  = val;
        REG_TABLE_SIZE: tsize = val[5:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // one accepted key byte
    function void note_input(logic [7:0] ch, logic lk, logic ls);
      logic [63:0]    acc;
      logic [31:0]    h;
      logic [31:0]    eff;
      logic [31:0]    b;
      bucket_result_t r;
      acc = {32'd0, run_hash} * {32'd0, mult} + {56'd0, ch};
      // zero modulus stands for 2^32
      if (modv == 32'd0) h = acc[31:0];
      else h = 32'(acc % {32'd0, modv});
      if (!lk) begin
        run_hash = h;
        return;
      end
      // bucket count clamped to 1..TABLE_DEPTH
      if (tsize == 6'd0) eff = 32'd1;
      else if (tsize > TABLE_DEPTH) eff = TABLE_DEPTH;
      else eff = {26'd0, tsize};
      b = h % eff;
      r.key_hash = h;
      r.bucket   = b[4:0];
      r.collided = occupied[b[4:0]];
      occupied[b[4:0]] = 1'b1;
      if (r.collided && hits != COUNT_MAX) hits = hits + 10'd1;
      r.total    = hits;
      r.set_done = ls;
      if (int'(hits) > peak_total) peak_total = int'(hits);
      pending_q = {pending_q, r};
      run_hash = '0;
      if (ls) begin
        occupied = '0;
        hits     = '0;
      end
    endfunction

    // one accepted result item
    function void check_result(logic [47:0] d, logic last);
      bucket_result_t e;
      logic           bad;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hash %h bucket %0d col %0b total %0d done %0b",
                   d[31:0], d[36:32], d[37], d[47:38], last);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (e.set_done) sets_closed++;
      bad = (d[31:0] !== e.key_hash) || (d[36:32] !== e.bucket) ||
            (d[37] !== e.collided) || (d[47:38] !== e.total) || (last !== e.set_done);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d:", checked);
          $display("  exp hash %h bucket %0d col %0b total %0d done %0b",
                   e.key_hash, e.bucket, e.collided, e.total, e.set_done);
          $display("  got hash %h bucket %0d col %0b total %0d done %0b",
                   d[31:0], d[36:32], d[37], d[47:38], last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] key_char
  logic        s_tlast;   // last_of_key
  logic        s_tuser;   // last_of_set
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [31:0] key_hash, [36:32] bucket,
                          // [37] collided, [47:38] collision_total
  logic        m_tlast;   // set_done

  hash_scoreboard board;
  bit             calm;      // no idling on either side
  bit             hold_req;  // receiver long hold-off request
  int             bytes_sent;
  int             stall_cnt;

  poly_hash_bucket_collision #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(99) < 11) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one byte, return once it is taken
  task automatic send_item(input logic [7:0] ch, input logic lk, input logic ls);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 11) gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= lk;
    s_tuser  <= ls;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(ch, lk, ls);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // drain, let any byte in flight finish, then load all three registers
  task automatic apply_settings(input logic [31:0] m, input logic [31:0] md,
                                input logic [31:0] ts);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_MULTIPLIER, m);
    write_reg(REG_MODULUS, md);
    write_reg(REG_TABLE_SIZE, ts);
  endtask

  // random byte with extra weight on the extremes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] m, md, ts;
    int          quota;
    int          len;
    int          sent_here;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    s_tuser    = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    stall_cnt  = 0;
    board      = new();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero key, max bytes, set mark without key mark, collisions
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h41, 1'b0, 1'b1);
    send_item(8'h42, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h07, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);

    // 2^32 modulus, full multiplier, oversize table, write to unused index
    apply_settings(32'hFFFF_FFFF, 32'd0, 32'd40);
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);

    // modulus one, zero table size, zero multiplier
    apply_settings(32'd0, 32'd1, 32'd0);
    send_item(8'hAA, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);

    // modulus two, unit multiplier, one bucket; upper data bits ignored
    apply_settings(32'd1, 32'd2, 32'hFFFF_FFC1);
    send_item(8'h03, 1'b1, 1'b0);
    send_item(8'hFE, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);

    // largest modulus with the table at its depth
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd32);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);

    // random phases over mixed settings
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(4))
        0:       m = 32'd0;
        1:       m = 32'd1;
        2:       m = 32'hFFFF_FFFF;
        3:       m = MULTIPLIER_RST;
        default: m = $urandom;
      endcase
      case ($urandom_range(6))
        0:       md = 32'd0;
        1:       md = 32'd1;
        2:       md = 32'd2;
        3:       md = 32'hFFFF_FFFF;
        4:       md = $urandom_range(1000, 2);
        5:       md = MODULUS_RST;
        default: md = $urandom | 32'd2;
      endcase
      case ($urandom_range(4))
        0:       ts = 32'd1;
        1:       ts = 32'd32;
        2:       ts = 32'd0;
        default: ts = $urandom;
      endcase
      apply_settings(m, md, ts);
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom);
      calm = (ph == 3);
      if (ph == 1) hold_req = 1'b1;
      quota     = $urandom_range(35, 20);
      sent_here = 0;
      while (sent_here < quota) begin
        if ($urandom_range(99) < 8) begin
          // noise: any flag combination, often a set mark on a middle byte
          send_item(pick_char(), 1'($urandom), 1'($urandom));
          sent_here++;
        end else begin
          len = $urandom_range(5, 1);
          for (int k = 1; k < len; k++) send_item(pick_char(), 1'b0, 1'b0);
          send_item(pick_char(), 1'b1, 1'($urandom_range(99) < 15));
          sent_here += len;
        end
      end
      calm = 1'b0;
    end

    // counter saturation: one bucket, one long set of single-byte keys
    apply_settings($urandom, $urandom | 32'd2, 32'($urandom_range(1, 0)));
    for (int k = 0; k < SAT_KEYS; k++)
      send_item(pick_char(), 1'b1, 1'(k == SAT_KEYS - 1));

    // drain and report
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d key bytes, %0d results, %0d closed key sets",
             bytes_sent, board.checked, board.sets_closed);
    $display("highest collision count %0d, %0d mismatches",
             board.peak_total, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/phbc_pkg.sv
rtl/phbc_ctrl.sv
rtl/phbc_dp.sv
rtl/poly_hash_bucket_collision.sv
tb/sv/poly_hash_bucket_collision_tb.sv
